// ===== hw/rtl/tta_pkg.sv =====
// ----------------------------------------------------------------------------
// tta_pkg
// Shared widths, codes and command/status types of the tag allocator.
// ----------------------------------------------------------------------------
package tta_pkg;

  localparam int TAG_COUNT   = 256;
  localparam int QUEUE_DEPTH = 16;

  localparam int TAG_W     = $clog2(TAG_COUNT);
  localparam int GRP_W     = TAG_W / 2;
  localparam int GRP_SIZE  = 1 << GRP_W;
  localparam int GRP_COUNT = TAG_COUNT / GRP_SIZE;
  localparam int CNT_W     = $clog2(TAG_COUNT + 1);
  localparam int REF_W     = 16;
  localparam int QA_W      = $clog2(QUEUE_DEPTH);
  localparam int LVL_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_ISSUE   = 2'd0,
    ACT_RESP    = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_ISSUED   = 3'd0,
    KIND_QUEUED   = 3'd1,
    KIND_DONE     = 3'd2,
    KIND_TIMEOUT  = 3'd3,
    KIND_IGNORED  = 3'd4,
    KIND_REJECTED = 3'd5
  } kind_t;

  typedef struct packed {
    logic load;
    logic seek;
    logic pick;
    logic push;
    logic reject;
    logic ignore;
    logic release_tag;
    logic report;
    logic drain;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    full;
    logic    q_full;
    logic    tag_hit;
    logic    pending;
  } status_t;

  // lowest set bit of one group
  function automatic logic [GRP_W-1:0] low_index(input logic [GRP_SIZE-1:0] v);
    logic [GRP_W-1:0] idx;
    idx = '0;
    for (int i = GRP_SIZE - 1; i >= 0; i--) begin
      if (v[i]) idx = GRP_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/tta_ctrl.sv =====
// ----------------------------------------------------------------------------
// tta_ctrl
// Sequencer: decodes the item and steps the datapath through search,
// release, report and queue drain, or has it queue, reject or ignore it.
// ----------------------------------------------------------------------------
module tta_ctrl import tta_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  status_t stat,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_PICK   = 5'b00100,
    S_REPORT = 5'b01000,
    S_DRAIN  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (stat.act) inside
          ACT_ISSUE: begin
            if (!stat.full) begin
              cmd.seek   = 1'b1;
              state_next = S_PICK;
            end else if (!stat.q_full) begin
              cmd.push = 1'b1;
            end else begin
              cmd.reject = 1'b1;
            end
          end
          ACT_RESP, ACT_TIMEOUT: begin
            if (stat.tag_hit) begin
              cmd.release_tag = 1'b1;
              state_next      = S_REPORT;
            end else begin
              cmd.ignore = 1'b1;
            end
          end
          default: begin
            cmd.ignore = 1'b1;
          end
        endcase
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = S_IDLE;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = stat.pending ? S_DRAIN : S_IDLE;
      end
      S_DRAIN: begin
        cmd.drain  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hw/rtl/tta_dpath.sv =====
// ----------------------------------------------------------------------------
// tta_dpath
// Tag busy map, owner and pending memories, two-level free-tag search,
// counters and registered result.
// ----------------------------------------------------------------------------
module tta_dpath import tta_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output status_t          stat,
  input  logic [1:0]       action,
  input  logic [TAG_W-1:0] tag,
  input  logic [REF_W-1:0] request_ref,
  output logic             strobe,
  output logic [2:0]       kind,
  output logic [TAG_W-1:0] out_tag,
  output logic [REF_W-1:0] out_ref,
  output logic [CNT_W-1:0] active_count,
  output logic             last
);

  localparam logic [GRP_SIZE-1:0] ONES = {GRP_SIZE{1'b1}};

  action_t          act_r;
  logic [TAG_W-1:0] tag_r;
  logic [REF_W-1:0] ref_r;

  logic [GRP_COUNT-1:0][GRP_SIZE-1:0] busy_map;
  logic [CNT_W-1:0] busy_count;
  logic [TAG_W-1:0] next_tag;
  logic [LVL_W-1:0] level;
  logic [QA_W-1:0]  head;

  logic [REF_W-1:0] owner_mem [TAG_COUNT];
  logic [REF_W-1:0] owner_rd;
  logic [REF_W-1:0] queue_mem [QUEUE_DEPTH];
  logic [REF_W-1:0] queue_rd;

  logic [GRP_W-1:0] grp_r, min_r;

  logic [GRP_W-1:0]       start_grp, start_bit, hop_grp, pick_bit;
  logic [GRP_SIZE-1:0]    start_free, pick_free;
  logic                   start_hit;
  logic [GRP_COUNT-1:0]   grp_open, grp_rot;
  logic [2*GRP_COUNT-1:0] grp_dbl;
  logic [GRP_W:0]         rot_amt;
  logic [TAG_W-1:0]       pick_tag;

  logic             own_we;
  logic [TAG_W-1:0] own_wa;
  logic [REF_W-1:0] own_wd;

  // search step one: start group from next_tag upward, else first open group
  // after it (wrapping round to the start group's low bits)
  always_comb begin
    start_grp  = next_tag[TAG_W-1:GRP_W];
    start_bit  = next_tag[GRP_W-1:0];
    start_free = ~busy_map[start_grp] & (ONES << start_bit);
    start_hit  = |start_free;
    for (int g = 0; g < GRP_COUNT; g++) begin
      grp_open[g] = ~&busy_map[g];
    end
    grp_dbl = {grp_open, grp_open};
    rot_amt = (GRP_W+1)'(start_grp) + (GRP_W+1)'(1);
    grp_rot = grp_dbl[rot_amt +: GRP_COUNT];
    hop_grp = start_grp + GRP_W'(1) + low_index(grp_rot);
  end

  // search step two: first free bit in the chosen group
  always_comb begin
    pick_free = ~busy_map[grp_r] & (ONES << min_r);
    pick_bit  = low_index(pick_free);
    pick_tag  = {grp_r, pick_bit};
  end

  always_comb begin
    stat.act     = act_r;
    stat.full    = (busy_count == CNT_W'(TAG_COUNT));
    stat.q_full  = (level == LVL_W'(QUEUE_DEPTH));
    stat.tag_hit = busy_map[tag_r[TAG_W-1:GRP_W]][tag_r[GRP_W-1:0]];
    stat.pending = (level != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action_t'(action);
      tag_r <= tag;
      ref_r <= request_ref;
    end
    if (cmd.seek) begin
      grp_r <= start_hit ? start_grp : hop_grp;
      min_r <= start_hit ? start_bit : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_map   <= '0;
      busy_count <= '0;
      next_tag   <= '0;
      level      <= '0;
      head       <= '0;
      strobe     <= 1'b0;
    end else begin
      if (cmd.pick) begin
        busy_map[pick_tag[TAG_W-1:GRP_W]][pick_tag[GRP_W-1:0]] <= 1'b1;
        busy_count <= busy_count + CNT_W'(1);
        next_tag   <= pick_tag;
      end
      if (cmd.release_tag) begin
        busy_map[tag_r[TAG_W-1:GRP_W]][tag_r[GRP_W-1:0]] <= 1'b0;
        busy_count <= busy_count - CNT_W'(1);
      end
      // a queued item only exists while every tag is busy, so the tag just
      // freed is the only free one
      if (cmd.drain) begin
        busy_map[tag_r[TAG_W-1:GRP_W]][tag_r[GRP_W-1:0]] <= 1'b1;
        busy_count <= busy_count + CNT_W'(1);
        next_tag   <= tag_r + TAG_W'(1);
        head       <= head + QA_W'(1);
        level      <= level - LVL_W'(1);
      end
      if (cmd.push) begin
        level <= level + LVL_W'(1);
      end
      strobe <= cmd.pick | cmd.push | cmd.reject | cmd.ignore | cmd.report | cmd.drain;
    end
  end

  always_comb begin
    own_we = cmd.pick | cmd.drain;
    own_wa = cmd.pick ? pick_tag : tag_r;
    own_wd = cmd.pick ? ref_r : queue_rd;
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      owner_mem[own_wa] <= own_wd;
    end
    owner_rd <= owner_mem[tag_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      queue_mem[head + level[QA_W-1:0]] <= ref_r;
    end
    queue_rd <= queue_mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      kind         <= KIND_ISSUED;
      out_tag      <= pick_tag;
      out_ref      <= ref_r;
      active_count <= busy_count + CNT_W'(1);
      last         <= 1'b1;
    end else if (cmd.push) begin
      kind         <= KIND_QUEUED;
      out_tag      <= '0;
      out_ref      <= ref_r;
      active_count <= busy_count;
      last         <= 1'b1;
    end else if (cmd.reject) begin
      kind         <= KIND_REJECTED;
      out_tag      <= '0;
      out_ref      <= ref_r;
      active_count <= busy_count;
      last         <= 1'b1;
    end else if (cmd.ignore) begin
      kind         <= KIND_IGNORED;
      out_tag      <= tag_r;
      out_ref      <= '0;
      active_count <= busy_count;
      last         <= 1'b1;
    end else if (cmd.report) begin
      kind         <= (act_r == ACT_RESP) ? KIND_DONE : KIND_TIMEOUT;
      out_tag      <= tag_r;
      out_ref      <= owner_rd;
      active_count <= busy_count;
      last         <= (level == '0);
    end else if (cmd.drain) begin
      kind         <= KIND_ISSUED;
      out_tag      <= tag_r;
      out_ref      <= queue_rd;
      active_count <= busy_count + CNT_W'(1);
      last         <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/transaction_tag_allocator.sv =====
// ----------------------------------------------------------------------------
// transaction_tag_allocator
// Issues 8-bit transaction tags, tracks outstanding ones and queues requests
// while every tag is in use.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each result appears
// for exactly one cycle with strobe high and cannot be held off. An issue
// that gets a tag steps through accept, decode with group search, and bit
// search, its result shown in the cycle busy falls; a queued or rejected
// issue, or an ignored item, through accept and decode; a response or
// timeout through accept, decode and report, plus a drain when it serves a
// queued request, the two results then on consecutive cycles. The steps
// follow from the two-step tag search and the registered owner-memory read.
module transaction_tag_allocator import tta_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action,
  input  logic [TAG_W-1:0] tag,
  input  logic [REF_W-1:0] request_ref,
  output logic             strobe,
  output logic [2:0]       kind,
  output logic [TAG_W-1:0] out_tag,
  output logic [REF_W-1:0] out_ref,
  output logic [CNT_W-1:0] active_count,
  output logic             last
);

  cmd_t    cmd;
  status_t stat;

  tta_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tta_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (action),
    .tag          (tag),
    .request_ref  (request_ref),
    .strobe       (strobe),
    .kind         (kind),
    .out_tag      (out_tag),
    .out_ref      (out_ref),
    .active_count (active_count),
    .last         (last)
  );

endmodule
